FILE: rtl/spot_pkg.sv
// Shared constants, payload types and address helpers for the session path overlay table.
`default_nettype none
package spot_pkg;

   localparam int ENTRIES       = 16;
   localparam int CONTENT_BYTES = 4096;
   localparam int PATH_BYTES    = 256;

   localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SCNT_W      = $clog2(ENTRIES + 1);
   localparam int PC_W        = $clog2(PATH_BYTES + 1);
   localparam int PP_W        = $clog2(PATH_BYTES);
   localparam int PL_W        = (PATH_BYTES > 2) ? $clog2(PATH_BYTES) : 1;
   localparam int CL_W        = $clog2(CONTENT_BYTES + 1);
   localparam int CA_W        = (CONTENT_BYTES > 1) ? $clog2(CONTENT_BYTES) : 1;
   localparam int SC_W        = $clog2(CONTENT_BYTES + 2);
   localparam int IDX_W       = (PC_W > CL_W) ? PC_W : CL_W;
   localparam int CMP_W       = (CL_W > 13) ? CL_W : 13;
   localparam int PATH_ADDR_W = $clog2(ENTRIES * PATH_BYTES);
   localparam int CONT_ADDR_W = (ENTRIES * CONTENT_BYTES > 1) ?
                                $clog2(ENTRIES * CONTENT_BYTES) : 1;

   localparam logic [2:0] OP_PATH_BYTE = 3'd0;
   localparam logic [2:0] OP_DATA_BYTE = 3'd1;
   localparam logic [2:0] OP_WRITE     = 3'd2;
   localparam logic [2:0] OP_LOOKUP    = 3'd3;
   localparam logic [2:0] OP_TRUNCATE  = 3'd4;
   localparam logic [2:0] OP_REAP      = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_SPACE  = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  byte_value;
      logic [31:0] session;
      logic [11:0] offset;
      logic [12:0] read_limit;
      logic [31:0] new_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] length;
      logic [7:0]  data_byte;
   } rsp_type;

   function automatic logic [PATH_ADDR_W-1:0] path_addr(input logic [SLOT_W-1:0] slot,
                                                        input logic [PP_W-1:0] pos);
      path_addr = PATH_ADDR_W'(PATH_ADDR_W'(slot) * PATH_ADDR_W'(PATH_BYTES))
                  + PATH_ADDR_W'(pos);
   endfunction

   function automatic logic [CONT_ADDR_W-1:0] cont_addr(input logic [SLOT_W-1:0] slot,
                                                        input logic [CA_W-1:0] pos);
      cont_addr = CONT_ADDR_W'(CONT_ADDR_W'(slot) * CONT_ADDR_W'(CONTENT_BYTES))
                  + CONT_ADDR_W'(pos);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/spot_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module spot_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/session_path_overlay_table_top.sv
// Top level of the session path overlay table: command sequencer around four RAMs.
`default_nettype none
// Byte transfers never raise busy and give no result.
// A command scans the slots in turn and compares path bytes with each slot whose
// session and path length match (a reap frees every slot of the session instead), then
// resolves; a write then copies stored path and content, a lookup may read a byte, and a truncate clears any new tail.
// A write of overfull content never raises busy. The strobe comes as busy falls and
// cannot be stalled; synchronous reset empties table and buffers.
module session_path_overlay_table_top
   import spot_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   output rsp_type      rsp_payload
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SCAN    = 4'd1;
   localparam logic [3:0] S_CMP     = 4'd2;
   localparam logic [3:0] S_RESOLVE = 4'd3;
   localparam logic [3:0] S_WPATH   = 4'd4;
   localparam logic [3:0] S_WDATA   = 4'd5;
   localparam logic [3:0] S_LREAD   = 4'd6;
   localparam logic [3:0] S_ZERO    = 4'd7;

   logic [3:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SCNT_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] tgt_ff, tgt_in;
   logic              free_v_ff, free_v_in;
   logic [SLOT_W-1:0] free_ff, free_in;
   logic              cmp_v_ff, cmp_v_in;
   logic              pwr_v_ff, pwr_v_in;
   logic [PATH_ADDR_W-1:0] pwr_addr_ff, pwr_addr_in;
   logic              cwr_v_ff, cwr_v_in;
   logic [CONT_ADDR_W-1:0] cwr_addr_ff, cwr_addr_in;
   logic [PC_W-1:0]   pcnt_ff, pcnt_in;
   logic              pend_end_ff, pend_end_in;
   logic              pclosed_ff, pclosed_in;
   logic [SC_W-1:0]   scnt_ff, scnt_in;
   logic              dclosed_ff, dclosed_in;
   logic              rsp_v_ff, rsp_v_in;
   rsp_type           rsp_ff, rsp_in;

   logic              used_ff [ENTRIES];
   logic              used_in [ENTRIES];
   logic [31:0]       sess_ff [ENTRIES];
   logic [31:0]       sess_in [ENTRIES];
   logic [PL_W-1:0]   plen_ff [ENTRIES];
   logic [PL_W-1:0]   plen_in [ENTRIES];
   logic [CL_W-1:0]   clen_ff [ENTRIES];
   logic [CL_W-1:0]   clen_in [ENTRIES];

   // RAM port signals.
   logic              pend_we, pend_re;
   logic [PP_W-1:0]   pend_wa, pend_ra;
   logic [7:0]        pend_rd;
   logic              stg_we, stg_re;
   logic [CA_W-1:0]   stg_wa, stg_ra;
   logic [7:0]        stg_rd;
   logic              path_re;
   logic [PATH_ADDR_W-1:0] path_ra;
   logic [7:0]        path_rd;
   logic              cont_we, cont_re;
   logic [CONT_ADDR_W-1:0] cont_wa, cont_ra;
   logic [7:0]        cont_wd, cont_rd;

   logic [SLOT_W-1:0] cur;
   logic [PC_W-1:0]   base_cnt, cplen;
   logic              base_end;
   logic [SC_W-1:0]   sbase;
   logic [CMP_W-1:0]  look_len;

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;
   assign cur         = slot_ff[SLOT_W-1:0];
   // Stored paths are cut one short of the buffer size.
   assign cplen = (pcnt_ff > PC_W'(PATH_BYTES - 1)) ? PC_W'(PATH_BYTES - 1) : pcnt_ff;

   // Copy writes follow their reads in the next cycle through pipe registers; zero fill writes directly.
   assign cont_we = cwr_v_ff || (state_ff == S_ZERO && idx_ff < IDX_W'(req_ff.new_length));
   assign cont_wa = cwr_v_ff ? cwr_addr_ff : cont_addr(tgt_ff, idx_ff[CA_W-1:0]);
   assign cont_wd = cwr_v_ff ? stg_rd : 8'd0;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      slot_in     = slot_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      tgt_in      = tgt_ff;
      free_v_in   = free_v_ff;
      free_in     = free_ff;
      cmp_v_in    = 1'b0;
      pwr_v_in    = 1'b0;
      pwr_addr_in = pwr_addr_ff;
      cwr_v_in    = 1'b0;
      cwr_addr_in = cwr_addr_ff;
      pcnt_in     = pcnt_ff;
      pend_end_in = pend_end_ff;
      pclosed_in  = pclosed_ff;
      scnt_in     = scnt_ff;
      dclosed_in  = dclosed_ff;
      rsp_v_in    = 1'b0;
      rsp_in      = rsp_ff;
      used_in     = used_ff;
      sess_in     = sess_ff;
      plen_in     = plen_ff;
      clen_in     = clen_ff;
      pend_we = 1'b0;
      pend_wa = base_cnt[PP_W-1:0];
      pend_re = 1'b0;
      pend_ra = idx_ff[PP_W-1:0];
      stg_we  = 1'b0;
      stg_wa  = sbase[CA_W-1:0];
      stg_re  = 1'b0;
      stg_ra  = idx_ff[CA_W-1:0];
      path_re = 1'b0;
      path_ra = path_addr(cur, idx_ff[PP_W-1:0]);
      cont_re = 1'b0;
      cont_ra = cont_addr(tgt_ff, CA_W'(req_ff.offset));
      base_cnt = pclosed_ff ? '0 : pcnt_ff;
      base_end = pclosed_ff ? 1'b0 : pend_end_ff;
      sbase    = dclosed_ff ? '0 : scnt_ff;
      look_len = (CMP_W'(clen_ff[tgt_ff]) < CMP_W'(req_ff.read_limit)) ?
                 CMP_W'(clen_ff[tgt_ff]) : CMP_W'(req_ff.read_limit);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_payload;
               case (req_payload.op)
                  OP_PATH_BYTE: begin
                     // A zero byte ends the path; later bytes are dropped.
                     pclosed_in  = 1'b0;
                     pcnt_in     = base_cnt;
                     pend_end_in = base_end;
                     if (!base_end) begin
                        if (req_payload.byte_value == 8'd0) begin
                           pend_end_in = 1'b1;
                        end else if (base_cnt < PC_W'(PATH_BYTES)) begin
                           pend_we = 1'b1;
                           pcnt_in = base_cnt + PC_W'(1);
                        end
                     end
                  end
                  OP_DATA_BYTE: begin
                     dclosed_in = 1'b0;
                     if (sbase < SC_W'(CONTENT_BYTES)) begin
                        stg_we  = 1'b1;
                        scnt_in = sbase + SC_W'(1);
                     end else begin
                        scnt_in = SC_W'(CONTENT_BYTES + 1);
                     end
                  end
                  OP_WRITE, OP_LOOKUP, OP_TRUNCATE, OP_REAP: begin
                     pclosed_in = 1'b1;
                     dclosed_in = 1'b1;
                     slot_in    = '0;
                     found_in   = 1'b0;
                     free_v_in  = 1'b0;
                     if (req_payload.op == OP_WRITE && scnt_ff > SC_W'(CONTENT_BYTES)) begin
                        rsp_v_in = 1'b1;
                        rsp_in   = '{status: ST_NO_SPACE, length: 13'd0, data_byte: 8'd0};
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (slot_ff == SCNT_W'(ENTRIES)) begin
               state_in = S_RESOLVE;
            end else begin
               slot_in = slot_ff + SCNT_W'(1);
               if (req_ff.op == OP_REAP) begin
                  if (used_ff[cur] && sess_ff[cur] == req_ff.session) begin
                     used_in[cur] = 1'b0;
                  end
               end else begin
                  if (!used_ff[cur] && !free_v_ff) begin
                     free_v_in = 1'b1;
                     free_in   = cur;
                  end
                  if (used_ff[cur] && sess_ff[cur] == req_ff.session &&
                      PC_W'(plen_ff[cur]) == pcnt_ff && pcnt_ff < PC_W'(PATH_BYTES)) begin
                     slot_in  = slot_ff;
                     idx_in   = '0;
                     state_in = S_CMP;
                  end
               end
            end
         end
         S_CMP: begin
            // One path byte is read each cycle and checked in the next.
            if (cmp_v_ff && path_rd != pend_rd) begin
               slot_in  = slot_ff + SCNT_W'(1);
               state_in = S_SCAN;
            end else if (idx_ff < IDX_W'(pcnt_ff)) begin
               pend_re  = 1'b1;
               path_re  = 1'b1;
               cmp_v_in = 1'b1;
               idx_in   = idx_ff + IDX_W'(1);
            end else begin
               found_in = 1'b1;
               tgt_in   = cur;
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            rsp_in   = '{status: ST_OK, length: 13'd0, data_byte: 8'd0};
            idx_in   = '0;
            state_in = S_IDLE;
            rsp_v_in = 1'b1;
            case (req_ff.op)
               OP_WRITE: begin
                  if (found_ff || free_v_ff) begin
                     tgt_in           = found_ff ? tgt_ff : free_ff;
                     sess_in[tgt_in]  = req_ff.session;
                     plen_in[tgt_in]  = PL_W'(cplen);
                     clen_in[tgt_in]  = CL_W'(scnt_ff);
                     used_in[tgt_in]  = 1'b1;
                     rsp_v_in         = 1'b0;
                     state_in         = S_WPATH;
                  end else begin
                     rsp_in.status = ST_NO_SPACE;
                  end
               end
               OP_LOOKUP: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     rsp_in.length = 13'(look_len);
                     if (CMP_W'(req_ff.offset) < look_len &&
                         32'(req_ff.offset) < 32'(CONTENT_BYTES)) begin
                        cont_re  = 1'b1;
                        rsp_v_in = 1'b0;
                        state_in = S_LREAD;
                     end
                  end
               end
               OP_TRUNCATE: begin
                  if (found_ff) begin
                     if ({1'b0, req_ff.new_length} > 33'(CONTENT_BYTES)) begin
                        rsp_in.status = ST_NO_SPACE;
                     end else begin
                        idx_in   = IDX_W'(clen_ff[tgt_ff]);
                        rsp_v_in = 1'b0;
                        state_in = S_ZERO;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_WPATH: begin
            if (idx_ff < IDX_W'(cplen)) begin
               pend_re     = 1'b1;
               pwr_v_in    = 1'b1;
               pwr_addr_in = path_addr(tgt_ff, idx_ff[PP_W-1:0]);
               idx_in      = idx_ff + IDX_W'(1);
            end else begin
               idx_in   = '0;
               state_in = S_WDATA;
            end
         end
         S_WDATA: begin
            if (idx_ff < IDX_W'(scnt_ff)) begin
               stg_re      = 1'b1;
               cwr_v_in    = 1'b1;
               cwr_addr_in = cont_addr(tgt_ff, idx_ff[CA_W-1:0]);
               idx_in      = idx_ff + IDX_W'(1);
            end else begin
               rsp_v_in = 1'b1;
               rsp_in   = '{status: ST_OK, length: 13'd0, data_byte: 8'd0};
               state_in = S_IDLE;
            end
         end
         S_LREAD: begin
            rsp_v_in         = 1'b1;
            rsp_in.data_byte = cont_rd;
            state_in         = S_IDLE;
         end
         S_ZERO: begin
            // Growing an overlay clears the new tail one byte a cycle; a shrink only sets the length.
            if (idx_ff < IDX_W'(req_ff.new_length)) begin
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               clen_in[tgt_ff] = CL_W'(req_ff.new_length);
               rsp_v_in        = 1'b1;
               rsp_in          = '{status: ST_OK, length: 13'd0, data_byte: 8'd0};
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cmp_v_ff    <= 1'b0;
         pwr_v_ff    <= 1'b0;
         cwr_v_ff    <= 1'b0;
         pcnt_ff     <= '0;
         pend_end_ff <= 1'b0;
         pclosed_ff  <= 1'b0;
         scnt_ff     <= '0;
         dclosed_ff  <= 1'b0;
         rsp_v_ff    <= 1'b0;
         found_ff    <= 1'b0;
         free_v_ff   <= 1'b0;
         slot_ff     <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            used_ff[i] <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         cmp_v_ff    <= cmp_v_in;
         pwr_v_ff    <= pwr_v_in;
         cwr_v_ff    <= cwr_v_in;
         pcnt_ff     <= pcnt_in;
         pend_end_ff <= pend_end_in;
         pclosed_ff  <= pclosed_in;
         scnt_ff     <= scnt_in;
         dclosed_ff  <= dclosed_in;
         rsp_v_ff    <= rsp_v_in;
         found_ff    <= found_in;
         free_v_ff   <= free_v_in;
         slot_ff     <= slot_in;
         used_ff     <= used_in;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      tgt_ff      <= tgt_in;
      free_ff     <= free_in;
      pwr_addr_ff <= pwr_addr_in;
      cwr_addr_ff <= cwr_addr_in;
      rsp_ff      <= rsp_in;
      sess_ff     <= sess_in;
      plen_ff     <= plen_in;
      clen_ff     <= clen_in;
   end

   spot_ram #(.DEPTH(PATH_BYTES), .WIDTH(8), .ADDR_W(PP_W)) u_pend (
      .clock(clock), .wr_en(pend_we), .wr_addr(pend_wa), .wr_data(req_payload.byte_value),
      .rd_en(pend_re), .rd_addr(pend_ra), .rd_data(pend_rd));

   spot_ram #(.DEPTH(CONTENT_BYTES), .WIDTH(8), .ADDR_W(CA_W)) u_stage (
      .clock(clock), .wr_en(stg_we), .wr_addr(stg_wa), .wr_data(req_payload.byte_value),
      .rd_en(stg_re), .rd_addr(stg_ra), .rd_data(stg_rd));

   spot_ram #(.DEPTH(ENTRIES * PATH_BYTES), .WIDTH(8), .ADDR_W(PATH_ADDR_W)) u_path (
      .clock(clock), .wr_en(pwr_v_ff), .wr_addr(pwr_addr_ff), .wr_data(pend_rd),
      .rd_en(path_re), .rd_addr(path_ra), .rd_data(path_rd));

   spot_ram #(.DEPTH(ENTRIES * CONTENT_BYTES), .WIDTH(8), .ADDR_W(CONT_ADDR_W)) u_cont (
      .clock(clock), .wr_en(cont_we), .wr_addr(cont_wa), .wr_data(cont_wd),
      .rd_en(cont_re), .rd_addr(cont_ra), .rd_data(cont_rd));

endmodule
`default_nettype wire
